>>> design/dls_pkg.sv
// Shared types and constants for the daily light schedule dimmer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package dls_pkg;

  localparam int unsigned SecW      = 17;
  localparam int unsigned MinW      = 11;
  localparam int unsigned PctW      = 7;
  localparam int unsigned FacW      = 9;
  localparam int unsigned FacFrac   = 8;
  localparam int unsigned NumW      = 24;
  localparam int unsigned QuoW      = 7;
  localparam int unsigned DutyW     = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 11;

  localparam logic [SecW:0]   SecsPerDay = 18'd86400;
  localparam logic [MinW-1:0] MinsPerDay = 11'd1440;
  localparam logic [PctW-1:0] MaxPct     = 7'd100;
  localparam logic [FacW-1:0] MaxFactor  = 9'd256;
  localparam logic [PctW+FacW-1:0] RoundQ8 = 16'd128;

  // floor(x / 60) equals (x * Min60Recip) >> Min60Shift for x below 2**17.
  localparam int unsigned      RecipW     = 18;
  localparam logic [RecipW-1:0] Min60Recip = 18'd139811;
  localparam int unsigned      Min60Shift = 23;

  // floor(b * 255 / 100) equals (b * PwmRecip) >> PwmShift for b up to 100.
  localparam int unsigned        PwmRecipW = 24;
  localparam logic [PwmRecipW-1:0] PwmRecip = 24'd10695720;
  localparam int unsigned        PwmShift  = 22;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START          = 3'd0,
    REG_DURATION       = 3'd1,
    REG_SUNRISE        = 3'd2,
    REG_SUNSET         = 3'd3,
    REG_TIMER_MODE     = 3'd4,
    REG_TARGET         = 3'd5,
    REG_CLIMATE_EN     = 3'd6,
    REG_CLIMATE_FACTOR = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PHASE_NIGHT   = 2'd0,
    PHASE_SUNRISE = 2'd1,
    PHASE_DAY     = 2'd2,
    PHASE_SUNSET  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [SecW-1:0] seconds_of_day;
    logic            time_valid;
  } dls_in_t;

  typedef struct packed {
    logic [PctW-1:0]  brightness_percent;
    logic [DutyW-1:0] pwm_duty;
    logic [1:0]       day_phase;
    logic [MinW-1:0]  minutes_to_change;
    logic             change_valid;
  } dls_out_t;

  // Configuration in the form the datapath uses: seconds, saturated values.
  typedef struct packed {
    logic [SecW-1:0] start_s;
    logic [SecW-1:0] dur_s;
    logic [SecW-1:0] rise_s;
    logic [SecW-1:0] set_s;
    logic            timer_mode;
    logic [PctW-1:0] target;
    logic            climate_en;
    logic [FacW-1:0] factor;
  } dls_cfg_t;

  // Data that travels beside the ramp division.
  typedef struct packed {
    logic            ramp_en;
    logic            t_nonzero;
    logic [PctW-1:0] base;
    phase_e          phase;
    logic [MinW-1:0] minutes;
    logic            change_valid;
  } dls_side_t;

endpackage

`default_nettype wire

>>> design/dls_sched.sv
// Schedule front end: time reduction, window test and ramp operands in three stages.
// Depends on dls_pkg.
`default_nettype none

module dls_sched (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  dls_pkg::dls_in_t           item_i,
  input  dls_pkg::dls_cfg_t          cfg_i,
  output logic                       valid_o,
  output logic [dls_pkg::NumW-1:0]   num_o,
  output logic [dls_pkg::SecW-1:0]   den_o,
  output dls_pkg::dls_side_t         side_o
);
  import dls_pkg::*;

  // Stage 1: time of day reduced into one day.
  logic            s1_vld_q;
  logic            s1_tv_q;
  logic [SecW-1:0] s1_now_q, s1_now_d;
  logic [SecW:0]   sec_x, sec_wrap;

  always_comb begin
    sec_x    = {1'b0, item_i.seconds_of_day};
    sec_wrap = sec_x - SecsPerDay;
    if (!item_i.time_valid) begin
      s1_now_d = '0;
    end else if (sec_x >= SecsPerDay) begin
      s1_now_d = sec_wrap[SecW-1:0];
    end else begin
      s1_now_d = item_i.seconds_of_day;
    end
  end

  // Stage 2: window membership and distances to its edges.
  logic            s2_vld_q;
  logic            s2_tv_q;
  logic            s2_on_q, s2_on_d;
  logic [SecW-1:0] s2_elapsed_q, s2_remaining_q, s2_secs_q;
  logic [SecW:0]   now_x, start_x, end_x;
  logic [SecW:0]   elapsed_x, remaining_x, to_start_x, secs_x;
  logic            wrap, after_start, before_end, before_ov;

  always_comb begin
    now_x       = {1'b0, s1_now_q};
    start_x     = {1'b0, cfg_i.start_s};
    end_x       = start_x + {1'b0, cfg_i.dur_s};
    wrap        = end_x > SecsPerDay;
    after_start = now_x >= start_x;
    before_end  = now_x < end_x;
    before_ov   = (now_x + SecsPerDay) < end_x;
    s2_on_d     = wrap ? (after_start | before_ov) : (after_start & before_end);
    elapsed_x   = after_start ? (now_x - start_x) : (now_x + SecsPerDay - start_x);
    remaining_x = after_start ? (end_x - now_x) : (end_x - SecsPerDay - now_x);
    to_start_x  = after_start ? (start_x + SecsPerDay - now_x) : (start_x - now_x);
    secs_x      = s2_on_d ? remaining_x : to_start_x;
  end

  // Stage 3: day phase, ramp numerator and divisor, minutes to the next edge.
  logic            in_rise, in_set;
  logic [SecW-1:0] ramp_t, ramp_l;
  logic [NumW-1:0] ramp_prod, num_d;
  logic [SecW+RecipW-1:0] min_prod;
  phase_e          phase;
  dls_side_t       side_d;

  always_comb begin
    in_rise   = s2_elapsed_q < cfg_i.rise_s;
    in_set    = s2_remaining_q < cfg_i.set_s;
    ramp_t    = in_rise ? s2_elapsed_q : s2_remaining_q;
    ramp_l    = in_rise ? cfg_i.rise_s : cfg_i.set_s;
    ramp_prod = {{(NumW-PctW){1'b0}}, cfg_i.target} * {{(NumW-SecW){1'b0}}, ramp_t};
    num_d     = ramp_prod + {{(NumW-SecW){1'b0}}, ramp_l >> 1};
    min_prod  = {{RecipW{1'b0}}, s2_secs_q} * {{SecW{1'b0}}, Min60Recip};

    if (!s2_on_q) begin
      phase = PHASE_NIGHT;
    end else if (in_rise) begin
      phase = PHASE_SUNRISE;
    end else if (in_set) begin
      phase = PHASE_SUNSET;
    end else begin
      phase = PHASE_DAY;
    end

    side_d.ramp_en      = cfg_i.timer_mode & s2_on_q & (in_rise | in_set);
    side_d.t_nonzero    = ramp_t != '0;
    side_d.base         = (cfg_i.timer_mode & ~s2_on_q) ? '0 : cfg_i.target;
    side_d.phase        = s2_tv_q ? phase : PHASE_DAY;
    side_d.change_valid = s2_tv_q & cfg_i.timer_mode;
    side_d.minutes      = side_d.change_valid ? min_prod[Min60Shift +: MinW] : '0;
  end

  logic            s3_vld_q;
  logic [NumW-1:0] s3_num_q;
  logic [SecW-1:0] s3_den_q;
  dls_side_t       s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tv_q        <= item_i.time_valid;
    s1_now_q       <= s1_now_d;
    s2_tv_q        <= s1_tv_q;
    s2_on_q        <= s2_on_d;
    s2_elapsed_q   <= elapsed_x[SecW-1:0];
    s2_remaining_q <= remaining_x[SecW-1:0];
    s2_secs_q      <= secs_x[SecW-1:0];
    s3_num_q       <= num_d;
    s3_den_q       <= ramp_l;
    s3_side_q      <= side_d;
  end

  assign valid_o = s3_vld_q;
  assign num_o   = s3_num_q;
  assign den_o   = s3_den_q;
  assign side_o  = s3_side_q;

endmodule

`default_nettype wire

>>> design/dls_div.sv
// Pipelined restoring divider for the ramp level, one quotient bit per stage.
// Depends on dls_pkg.
`default_nettype none

module dls_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [dls_pkg::NumW-1:0]  num_i,
  input  logic [dls_pkg::SecW-1:0]  den_i,
  input  dls_pkg::dls_side_t        side_i,
  output logic                      valid_o,
  output logic [dls_pkg::QuoW-1:0]  quo_o,
  output dls_pkg::dls_side_t        side_o
);
  import dls_pkg::*;

  logic            vld_q  [QuoW];
  logic [NumW-1:0] rem_q  [QuoW];
  logic [SecW-1:0] den_q  [QuoW];
  logic [QuoW-1:0] quo_q  [QuoW];
  dls_side_t       side_q [QuoW];

  logic            vld_s  [QuoW];
  logic [NumW-1:0] rem_s  [QuoW];
  logic [SecW-1:0] den_s  [QuoW];
  logic [QuoW-1:0] quo_s  [QuoW];
  dls_side_t       side_s [QuoW];

  logic [NumW:0]   shifted [QuoW];
  logic [NumW:0]   trial   [QuoW];
  logic            take    [QuoW];
  logic [NumW-1:0] rem_d   [QuoW];
  logic [QuoW-1:0] quo_d   [QuoW];

  always_comb begin
    vld_s[0]  = valid_i;
    rem_s[0]  = num_i;
    den_s[0]  = den_i;
    quo_s[0]  = '0;
    side_s[0] = side_i;
    for (int i = 1; i < QuoW; i++) begin
      vld_s[i]  = vld_q[i-1];
      rem_s[i]  = rem_q[i-1];
      den_s[i]  = den_q[i-1];
      quo_s[i]  = quo_q[i-1];
      side_s[i] = side_q[i-1];
    end
  end

  // Stage i decides quotient bit QuoW-1-i against the divisor shifted to that weight.
  always_comb begin
    for (int i = 0; i < QuoW; i++) begin
      shifted[i] = {{(NumW+1-SecW){1'b0}}, den_s[i]} << (QuoW - 1 - i);
      trial[i]   = {1'b0, rem_s[i]} - shifted[i];
      take[i]    = ~trial[i][NumW];
      rem_d[i]   = take[i] ? trial[i][NumW-1:0] : rem_s[i];
      quo_d[i]   = {quo_s[i][QuoW-2:0], take[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QuoW; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < QuoW; i++) begin
        vld_q[i] <= vld_s[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QuoW; i++) begin
      rem_q[i]  <= rem_d[i];
      den_q[i]  <= den_s[i];
      quo_q[i]  <= quo_d[i];
      side_q[i] <= side_s[i];
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign quo_o   = quo_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];

endmodule

`default_nettype wire

>>> design/dls_level.sv
// Output stages: ramp floor, climate scaling, PWM duty and the result register.
// Depends on dls_pkg.
`default_nettype none

module dls_level (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [dls_pkg::QuoW-1:0]  quo_i,
  input  dls_pkg::dls_side_t        side_i,
  input  dls_pkg::dls_cfg_t         cfg_i,
  output logic                      valid_o,
  output dls_pkg::dls_out_t         result_o
);
  import dls_pkg::*;

  // Stage 1: brightness before climate, and its product with the factor.
  logic                 l1_vld_q;
  logic [PctW-1:0]      l1_bright_q, bright_d, ramp_b;
  logic                 l1_apply_q, apply_d;
  logic [PctW+FacW-1:0] l1_prod_q, prod_d;
  dls_side_t            l1_side_q;

  always_comb begin
    ramp_b   = ((quo_i == '0) && side_i.t_nonzero) ? PctW'(1) : quo_i;
    bright_d = side_i.ramp_en ? ramp_b : side_i.base;
    apply_d  = cfg_i.timer_mode & cfg_i.climate_en & (bright_d != '0);
    prod_d   = {{FacW{1'b0}}, bright_d} * {{PctW{1'b0}}, cfg_i.factor};
  end

  // Stage 2: rounded and clamped climate result, then the duty product.
  logic                      l2_vld_q;
  logic [PctW-1:0]           l2_bright_q, final_d, clamped;
  logic [PctW+PwmRecipW-1:0] l2_pwm_q, pwm_d;
  dls_side_t                 l2_side_q;
  logic [PctW+FacW-1:0]      rounded;
  logic [PctW:0]             scaled;

  always_comb begin
    rounded = l1_prod_q + RoundQ8;
    scaled  = rounded[PctW+FacW-1:FacFrac];
    clamped = (scaled > {1'b0, MaxPct}) ? MaxPct : scaled[PctW-1:0];
    final_d = l1_apply_q ? clamped : l1_bright_q;
    pwm_d   = {{PwmRecipW{1'b0}}, final_d} * {{PctW{1'b0}}, PwmRecip};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_vld_q <= 1'b0;
      l2_vld_q <= 1'b0;
    end else begin
      l1_vld_q <= valid_i;
      l2_vld_q <= l1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l1_bright_q <= bright_d;
    l1_apply_q  <= apply_d;
    l1_prod_q   <= prod_d;
    l1_side_q   <= side_i;
    l2_bright_q <= final_d;
    l2_pwm_q    <= pwm_d;
    l2_side_q   <= l1_side_q;
  end

  assign valid_o                     = l2_vld_q;
  assign result_o.brightness_percent = l2_bright_q;
  assign result_o.pwm_duty           = l2_pwm_q[PwmShift +: DutyW];
  assign result_o.day_phase          = l2_side_q.phase;
  assign result_o.minutes_to_change  = l2_side_q.minutes;
  assign result_o.change_valid       = l2_side_q.change_valid;

endmodule

`default_nettype wire

>>> design/daily_light_schedule_dimmer_top.sv
// Top level of the daily light schedule dimmer: configuration registers and pipeline.
// Depends on dls_pkg, dls_sched, dls_div and dls_level.
//
// The block takes one transaction per clock cycle and never raises busy_o. Each
// transaction passes through three stages of time and window arithmetic, the
// seven-stage restoring divider that forms the ramp level, and two stages of
// climate scaling and duty computation. The result is shown for one cycle with
// result_valid_o and cannot be held off. A configuration write applies to
// transactions taken at any clock edge after the edge that writes it.
`default_nettype none

module daily_light_schedule_dimmer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  dls_pkg::dls_in_t              item_i,
  output logic                          result_valid_o,
  output dls_pkg::dls_out_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [dls_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dls_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dls_pkg::*;

  localparam int unsigned Latency = 3 + QuoW + 2;

  localparam logic [MinW-1:0] StartRst  = 11'd480;
  localparam logic [MinW-1:0] DurRst    = 11'd720;
  localparam logic [MinW-1:0] RiseRst   = 11'd60;
  localparam logic [MinW-1:0] SetRst    = 11'd60;
  localparam logic [FacW-1:0] FactorRst = 9'd256;

  localparam dls_cfg_t CfgRst = '{
    start_s:    SecW'(480 * 60),
    dur_s:      SecW'(720 * 60),
    rise_s:     SecW'(60 * 60),
    set_s:      SecW'(60 * 60),
    timer_mode: 1'b0,
    target:     '0,
    climate_en: 1'b0,
    factor:     FactorRst
  };

  function automatic logic [SecW-1:0] min_to_sec(input logic [MinW-1:0] m);
    logic [SecW-1:0] mx;
    mx = {{(SecW-MinW){1'b0}}, m};
    return (mx << 6) - (mx << 2);
  endfunction

  logic [MinW-1:0] start_min_q, dur_min_q, rise_min_q, set_min_q;
  logic            timer_q, clim_en_q;
  logic [PctW-1:0] target_q;
  logic [FacW-1:0] factor_q;
  dls_cfg_t        cfg_q, cfg_d;
  logic [MinW-1:0] start_red, dur_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_min_q <= StartRst;
      dur_min_q   <= DurRst;
      rise_min_q  <= RiseRst;
      set_min_q   <= SetRst;
      timer_q     <= 1'b0;
      target_q    <= '0;
      clim_en_q   <= 1'b0;
      factor_q    <= FactorRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_START:          start_min_q <= cfg_data_i[MinW-1:0];
        REG_DURATION:       dur_min_q   <= cfg_data_i[MinW-1:0];
        REG_SUNRISE:        rise_min_q  <= cfg_data_i[MinW-1:0];
        REG_SUNSET:         set_min_q   <= cfg_data_i[MinW-1:0];
        REG_TIMER_MODE:     timer_q     <= cfg_data_i[0];
        REG_TARGET:         target_q    <= cfg_data_i[PctW-1:0];
        REG_CLIMATE_EN:     clim_en_q   <= cfg_data_i[0];
        REG_CLIMATE_FACTOR: factor_q    <= cfg_data_i[FacW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    start_red        = (start_min_q >= MinsPerDay) ? (start_min_q - MinsPerDay) : start_min_q;
    dur_sat          = (dur_min_q > MinsPerDay) ? MinsPerDay : dur_min_q;
    cfg_d.start_s    = min_to_sec(start_red);
    cfg_d.dur_s      = min_to_sec(dur_sat);
    cfg_d.rise_s     = min_to_sec(rise_min_q);
    cfg_d.set_s      = min_to_sec(set_min_q);
    cfg_d.timer_mode = timer_q;
    cfg_d.target     = (target_q > MaxPct) ? MaxPct : target_q;
    cfg_d.climate_en = clim_en_q;
    cfg_d.factor     = (factor_q > MaxFactor) ? MaxFactor : factor_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic            accept;
  logic            sch_vld, div_vld;
  logic [NumW-1:0] sch_num;
  logic [SecW-1:0] sch_den;
  logic [QuoW-1:0] div_quo;
  dls_side_t       sch_side, div_side;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  dls_sched u_sched (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item_i),
    .cfg_i   (cfg_q),
    .valid_o (sch_vld),
    .num_o   (sch_num),
    .den_o   (sch_den),
    .side_o  (sch_side)
  );

  dls_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sch_vld),
    .num_i   (sch_num),
    .den_i   (sch_den),
    .side_i  (sch_side),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  dls_level u_level (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_vld),
    .quo_i    (div_quo),
    .side_i   (div_side),
    .cfg_i    (cfg_q),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency result_valid_o)
    else $error("Accepted transaction did not produce a result after the pipeline latency.");

  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.brightness_percent <= MaxPct) &&
      ((result_o.brightness_percent != MaxPct) || (result_o.pwm_duty == 8'd255)))
    else $error("Brightness or duty out of range.");

  a_minutes_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.change_valid) |-> (result_o.minutes_to_change == '0))
    else $error("Minutes to change reported without a valid schedule.");

  a_minutes_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.change_valid) |-> (result_o.minutes_to_change <= MinsPerDay))
    else $error("Minutes to change exceed one day.");

endmodule

`default_nettype wire
